[hw/rtl/xcfp_pkg.sv]
// Package for the XOR-checked frame parser.
// Holds the field widths, the hunt state codes, the register indexes and the
// result and status structs. Depends on nothing.
package xcfp_pkg;

	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned WORD_W      = 16;
	localparam int unsigned CFG_IDX_W   = 8;
	localparam int unsigned PAYLOAD_LEN = 9;
	localparam int unsigned IDX_W       = 4;
	localparam int unsigned HUNT_W      = 2;

	// Hunt state codes. The fourth code is unused and behaves as HUNT_FIRST.
	localparam logic [HUNT_W-1:0] HUNT_FIRST  = 2'd0;
	localparam logic [HUNT_W-1:0] HUNT_SECOND = 2'd1;
	localparam logic [HUNT_W-1:0] HUNT_BODY   = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_START  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SECOND_START = 8'd1;

	localparam logic [BYTE_W-1:0] FIRST_START_RESET  = 8'd170;
	localparam logic [BYTE_W-1:0] SECOND_START_RESET = 8'd85;

	localparam logic [IDX_W-1:0] CHECK_INDEX = IDX_W'(PAYLOAD_LEN);

	typedef struct packed {
		logic [WORD_W-1:0] ball_y;
		logic [WORD_W-1:0] ball_x;
		logic [WORD_W-1:0] goal_x;
		logic [WORD_W-1:0] goal_y;
		logic [BYTE_W-1:0] goal_color;
	} result_t;

	typedef struct packed {
		logic [HUNT_W-1:0] hunt_state;
		logic [IDX_W-1:0]  byte_index;
	} hunt_status_t;

endpackage

[hw/rtl/xcfp_if.sv]
// Channel interfaces of the XOR-checked frame parser: received bytes,
// decoded results and configuration writes. Depends on xcfp_pkg.

interface xcfp_byte_if;
	logic                         valid;
	logic                         ready;
	logic [xcfp_pkg::BYTE_W-1:0]  rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface xcfp_result_if;
	logic                         valid;
	logic                         ready;
	logic [xcfp_pkg::WORD_W-1:0]  ball_y;
	logic [xcfp_pkg::WORD_W-1:0]  ball_x;
	logic [xcfp_pkg::WORD_W-1:0]  goal_x;
	logic [xcfp_pkg::WORD_W-1:0]  goal_y;
	logic [xcfp_pkg::BYTE_W-1:0]  goal_color;

	modport source (output valid, output ball_y, output ball_x, output goal_x,
		output goal_y, output goal_color, input ready);
	modport sink (input valid, input ball_y, input ball_x, input goal_x,
		input goal_y, input goal_color, output ready);
endinterface

interface xcfp_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [xcfp_pkg::CFG_IDX_W-1:0]  reg_index;
	logic [xcfp_pkg::BYTE_W-1:0]     wr_data;

	modport source (output valid, output reg_index, output wr_data, input ready);
	modport sink (input valid, input reg_index, input wr_data, output ready);
endinterface

[hw/rtl/xcfp_hunt.sv]
// Frame hunt state machine with payload capture and running XOR.
// Depends on xcfp_pkg.
module xcfp_hunt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         take,
	input  logic [xcfp_pkg::BYTE_W-1:0]  rx_byte,
	input  logic [xcfp_pkg::BYTE_W-1:0]  first_start,
	input  logic [xcfp_pkg::BYTE_W-1:0]  second_start,
	output logic                         frame_ok,
	output xcfp_pkg::result_t            result,
	output xcfp_pkg::hunt_status_t       status
);

	logic [xcfp_pkg::HUNT_W-1:0] state_q, state_d;
	logic [xcfp_pkg::IDX_W-1:0]  index_q, index_d;
	logic [xcfp_pkg::BYTE_W-1:0] xor_q, xor_d;
	logic                        store_en;
	logic [xcfp_pkg::BYTE_W-1:0] payload_q [xcfp_pkg::PAYLOAD_LEN];

	always_comb begin
		state_d  = state_q;
		index_d  = index_q;
		xor_d    = xor_q;
		store_en = 1'b0;
		frame_ok = 1'b0;
		unique case (state_q)
			xcfp_pkg::HUNT_SECOND: begin
				// The second start byte is tested first so equal start bytes work.
				if (rx_byte == second_start) begin
					state_d = xcfp_pkg::HUNT_BODY;
					index_d = '0;
					xor_d   = '0;
				end else if (rx_byte == first_start) begin
					state_d = xcfp_pkg::HUNT_SECOND;
				end else begin
					state_d = xcfp_pkg::HUNT_FIRST;
				end
			end
			xcfp_pkg::HUNT_BODY: begin
				if (index_q < xcfp_pkg::CHECK_INDEX) begin
					store_en = 1'b1;
					xor_d    = xor_q ^ rx_byte;
					index_d  = index_q + 1'b1;
				end else begin
					state_d  = xcfp_pkg::HUNT_FIRST;
					index_d  = '0;
					frame_ok = (rx_byte == xor_q);
				end
			end
			default: begin
				state_d = (rx_byte == first_start) ? xcfp_pkg::HUNT_SECOND
					: xcfp_pkg::HUNT_FIRST;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= xcfp_pkg::HUNT_FIRST;
			index_q <= '0;
			xor_q   <= '0;
		end else if (take) begin
			state_q <= state_d;
			index_q <= index_d;
			xor_q   <= xor_d;
		end
	end

	// Payload bytes are always written in a frame before they are read.
	always_ff @(posedge clk) begin
		if (take && store_en) begin
			payload_q[index_q] <= rx_byte;
		end
	end

	assign result.ball_y     = {payload_q[0], payload_q[1]};
	assign result.ball_x     = {payload_q[2], payload_q[3]};
	assign result.goal_x     = {payload_q[4], payload_q[5]};
	assign result.goal_y     = {payload_q[6], payload_q[7]};
	assign result.goal_color = payload_q[8];

	assign status.hunt_state = state_q;
	assign status.byte_index = index_q;

endmodule

[hw/rtl/xor_checked_frame_parser.sv]
// Top level of the XOR-checked frame parser: configuration registers, the
// hunt engine and the result register. Depends on xcfp_pkg, xcfp_if and
// xcfp_hunt.
//
// Channel  Modport  Payload                                   Accepted when
// rx       sink     rx_byte (8)                               rx.valid && rx.ready
// res      source   ball_y, ball_x, goal_x, goal_y (16 each), res.valid && res.ready
//                   goal_color (8)
// cfg      sink     reg_index (8), wr_data (8)                cfg.valid && cfg.ready
//
// One item is taken per cycle on each channel that is ready. The hunt state,
// running XOR and payload bytes update at the edge that accepts the byte, and
// a good checksum byte loads the result register at that same edge, from which
// the result is offered. Reset returns the hunt to waiting for the first start
// byte and loads the start byte registers with their defaults. The byte input
// stalls only while the result register holds an item that is not being taken
// in the same cycle. The configuration channel is always ready.
module xor_checked_frame_parser (
	input  logic            clk,
	input  logic            arst_n,
	xcfp_byte_if.sink       rx,
	xcfp_result_if.source   res,
	xcfp_cfg_if.sink        cfg
);

	logic [xcfp_pkg::BYTE_W-1:0] first_start_q;
	logic [xcfp_pkg::BYTE_W-1:0] second_start_q;
	logic                        take;
	logic                        frame_ok;
	xcfp_pkg::result_t           result;
	xcfp_pkg::hunt_status_t      status;
	logic                        res_valid_q;
	xcfp_pkg::result_t           res_data_q;

	// Configuration writes are always taken. Indexes past the register list are
	// accepted and ignored.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_start_q  <= xcfp_pkg::FIRST_START_RESET;
			second_start_q <= xcfp_pkg::SECOND_START_RESET;
		end else if (cfg.valid) begin
			if (cfg.reg_index == xcfp_pkg::REG_FIRST_START) begin
				first_start_q <= cfg.wr_data;
			end
			if (cfg.reg_index == xcfp_pkg::REG_SECOND_START) begin
				second_start_q <= cfg.wr_data;
			end
		end
	end

	// A byte can be taken whenever the result register is empty or is being
	// emptied, since any byte may turn out to be a good checksum.
	assign rx.ready = !res_valid_q || res.ready;
	assign take     = rx.valid && rx.ready;

	xcfp_hunt u_hunt (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.rx_byte      (rx.rx_byte),
		.first_start  (first_start_q),
		.second_start (second_start_q),
		.frame_ok     (frame_ok),
		.result       (result),
		.status       (status)
	);

	// Result register. The payload bytes are all stored before the checksum
	// byte arrives, so the result can be copied at the checksum edge.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take && frame_ok) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && frame_ok) begin
			res_data_q <= result;
		end
	end

	assign res.valid      = res_valid_q;
	assign res.ball_y     = res_data_q.ball_y;
	assign res.ball_x     = res_data_q.ball_x;
	assign res.goal_x     = res_data_q.goal_x;
	assign res.goal_y     = res_data_q.goal_y;
	assign res.goal_color = res_data_q.goal_color;

`ifndef SYNTHESIS
	// A good checksum byte leaves a result waiting and the hunt restarted.
	a_result_after_check: assert property (@(posedge clk) disable iff (!arst_n)
		take && frame_ok |=> res.valid && status.hunt_state == xcfp_pkg::HUNT_FIRST)
		else $error("good frame did not produce a result");

	// The byte index never runs past the checksum position inside a frame.
	a_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		status.hunt_state == xcfp_pkg::HUNT_BODY |-> status.byte_index <= xcfp_pkg::CHECK_INDEX)
		else $error("byte index beyond checksum position");

	// The second start byte opens a frame at index zero.
	a_frame_start: assert property (@(posedge clk) disable iff (!arst_n)
		take && status.hunt_state == xcfp_pkg::HUNT_SECOND && rx.rx_byte == second_start_q
		|=> status.hunt_state == xcfp_pkg::HUNT_BODY && status.byte_index == '0)
		else $error("frame did not start after second start byte");

	// The byte input stalls only behind a result that is not being taken.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!rx.ready |-> res_valid_q && !res.ready)
		else $error("byte input stalled without a pending result");
`endif

endmodule
